[hdl/point_in_ellipsoid_test_core_defines.svh]
// Assertion macros used by the point-in-ellipsoid RTL.
`ifndef POINT_IN_ELLIPSOID_TEST_CORE_DEFINES_SVH
`define POINT_IN_ELLIPSOID_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pie_pkg.sv]
`default_nettype none

package pie_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int DIR_W     = 16;
    localparam int DIR_PACK_W = 3 * DIR_W;
    localparam int PROD_W    = DIFF_W + DIR_W;
    localparam int LOCAL_W   = PROD_W + 2;
    localparam int MAG_W     = LOCAL_W - 1;
    localparam int INV_W     = 20;
    localparam int INV_PACK_W = 3 * INV_W;
    localparam int TERM_W    = MAG_W + INV_W;
    // A term above 1.0 (2^44 in Q.44) forces the result; below it a term fits 45 bits.
    localparam int TERM_ONE_BIT = 44;
    localparam int SPLIT_LO_W = 23;
    localparam int SPLIT_HI_W = TERM_ONE_BIT + 1 - SPLIT_LO_W;
    localparam int HH_W      = 2 * SPLIT_HI_W;
    localparam int HL_W      = SPLIT_HI_W + SPLIT_LO_W;
    localparam int LL_W      = 2 * SPLIT_LO_W;
    localparam int SQ_W      = 2 * (TERM_ONE_BIT + 1);
    localparam int SUM_W     = SQ_W + 2;
    localparam int ONE_BIT   = 2 * TERM_ONE_BIT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = INV_PACK_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_AXIS_DIR_FIRST,
        REG_AXIS_DIR_SECOND,
        REG_AXIS_DIR_THIRD,
        REG_INV_HALF_AXES
    } pie_reg_idx_t;

    localparam logic [DIR_PACK_W-1:0] DIR_FIRST_RST  = 48'h0000_0000_4000;
    localparam logic [DIR_PACK_W-1:0] DIR_SECOND_RST = 48'h0000_4000_0000;
    localparam logic [DIR_PACK_W-1:0] DIR_THIRD_RST  = 48'h4000_0000_0000;
    localparam logic [INV_PACK_W-1:0] INV_RST        = {3{20'h04000}};

    localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << ONE_BIT;

    typedef struct packed {
        logic mul_en;
        logic split_en;
        logic sq_en;
    } pie_lane_en_t;

endpackage

`default_nettype wire

[hdl/pie_point_if.sv]
`default_nettype none

interface pie_point_if;
    import pie_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

`default_nettype wire

[hdl/pie_result_if.sv]
`default_nettype none

interface pie_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

[hdl/pie_cfg_if.sv]
`default_nettype none

interface pie_cfg_if;
    import pie_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/pie_term_lane.sv]
`default_nettype none

// One axis: scale the magnitude, flag terms above 1.0, square the rest.
module pie_term_lane (
    input  wire logic                          clk,
    input  wire pie_pkg::pie_lane_en_t         en,
    input  wire logic [pie_pkg::MAG_W-1:0]     mag,
    input  wire logic [pie_pkg::INV_W-1:0]     inv,
    output logic                               over,
    output logic [pie_pkg::SQ_W-1:0]           sq
);
    import pie_pkg::*;

    logic [TERM_W-1:0]      term_reg;
    logic                   over5_reg;
    logic [HH_W-1:0]        hh_reg;
    logic [HL_W-1:0]        hl_reg;
    logic [LL_W-1:0]        ll_reg;
    logic                   over6_reg;
    logic [SQ_W-1:0]        sq_reg;

    logic [SPLIT_HI_W-1:0]  hi;
    logic [SPLIT_LO_W-1:0]  lo;
    logic                   over_next;
    logic [SQ_W-1:0]        sq_next;

    assign hi = term_reg[TERM_ONE_BIT:SPLIT_LO_W];
    assign lo = term_reg[SPLIT_LO_W-1:0];

    // term > 2^44: anything above bit 44, or bit 44 with a nonzero remainder
    assign over_next = (|term_reg[TERM_W-1:TERM_ONE_BIT+1])
                     || (term_reg[TERM_ONE_BIT] && (|term_reg[TERM_ONE_BIT-1:0]));

    assign sq_next = (SQ_W'(hh_reg) << (2 * SPLIT_LO_W))
                   + (SQ_W'(hl_reg) << (SPLIT_LO_W + 1))
                   + SQ_W'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en.mul_en)
        begin
            term_reg <= TERM_W'(mag) * TERM_W'(inv);
        end
        if (en.split_en)
        begin
            over5_reg <= over_next;
            hh_reg    <= HH_W'(hi) * HH_W'(hi);
            hl_reg    <= HL_W'(hi) * HL_W'(lo);
            ll_reg    <= LL_W'(lo) * LL_W'(lo);
        end
        if (en.sq_en)
        begin
            over6_reg <= over5_reg;
            sq_reg    <= sq_next;
        end
    end

    assign over = over6_reg;
    assign sq   = sq_reg;
endmodule

`default_nettype wire

[hdl/point_in_ellipsoid_test_core.sv]
// Point-in-oriented-ellipsoid test.
// Channels: point (sink) takes one beat per query point, signed Q16.16 x/y/z;
// result (source) returns one beat per point, inside_res = 1 when the point's
// normalized squared distance is at most 1.0; cfg (sink) writes the centre,
// the three rotation columns and the reciprocal half-axes, and is always ready.
// Throughput: one point per cycle while results are taken; every stage has
// its own multipliers (9 for the rotation, 3 for scaling, 9 for the split
// squares), so nothing is shared between items.
// Stages: offset, rotation products, dot sum and magnitude, scaling, split
// squares, square assembly, sum and compare into the output register.
// Reset: all stage valids clear, the centre goes to 0, the rotation to the
// identity and the reciprocals to 1.0.
// Stall: a result beat not taken holds in the output register; earlier stages
// keep advancing into empty slots, and point.ready drops only once all seven
// stages hold an item.
`default_nettype none
`include "point_in_ellipsoid_test_core_defines.svh"

module point_in_ellipsoid_test_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pie_point_if.sink  point,
    pie_result_if.source result,
    pie_cfg_if.sink    cfg
);
    import pie_pkg::*;

    localparam int NUM_STAGES = 7;

    // configuration
    logic [COORD_W-1:0]     center_reg [3];
    logic [DIR_PACK_W-1:0]  dir_reg [3];
    logic [INV_PACK_W-1:0]  inv_reg;

    // pipeline control
    logic [NUM_STAGES:1]    v_reg;
    logic [NUM_STAGES+1:1]  adv;

    // stage data
    logic signed [DIFF_W-1:0]   d_reg [3];
    logic signed [PROD_W-1:0]   prod_reg [3][3];
    logic [MAG_W-1:0]           mag_reg [3];
    logic                       inside_reg;

    logic signed [DIFF_W-1:0]   d_next [3];
    logic signed [PROD_W-1:0]   prod_next [3][3];
    logic [MAG_W-1:0]           mag_next [3];
    logic [2:0]                 over6;
    logic [SQ_W-1:0]            sq6 [3];
    logic [SUM_W-1:0]           sum;
    pie_lane_en_t               lane_en;

    // Config writes; an index past the list is dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            dir_reg[0]    <= DIR_FIRST_RST;
            dir_reg[1]    <= DIR_SECOND_RST;
            dir_reg[2]    <= DIR_THIRD_RST;
            inv_reg       <= INV_RST;
        end
        else if (cfg.valid)
        begin
            unique case (pie_reg_idx_t'(cfg.index))
                REG_CENTER_X:        center_reg[0] <= cfg.data[COORD_W-1:0];
                REG_CENTER_Y:        center_reg[1] <= cfg.data[COORD_W-1:0];
                REG_CENTER_Z:        center_reg[2] <= cfg.data[COORD_W-1:0];
                REG_AXIS_DIR_FIRST:  dir_reg[0]    <= cfg.data[DIR_PACK_W-1:0];
                REG_AXIS_DIR_SECOND: dir_reg[1]    <= cfg.data[DIR_PACK_W-1:0];
                REG_AXIS_DIR_THIRD:  dir_reg[2]    <= cfg.data[DIR_PACK_W-1:0];
                REG_INV_HALF_AXES:   inv_reg       <= cfg.data[INV_PACK_W-1:0];
                default:             ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[NUM_STAGES+1] = result.ready;
        for (int s = NUM_STAGES; s >= 1; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign point.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= point.valid;
            end
            for (int s = 2; s <= NUM_STAGES; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Stage 1: offset from the centre, 33-bit signed.
    assign d_next[0] = $signed({point.point_x[COORD_W-1], point.point_x})
                     - $signed({center_reg[0][COORD_W-1], center_reg[0]});
    assign d_next[1] = $signed({point.point_y[COORD_W-1], point.point_y})
                     - $signed({center_reg[1][COORD_W-1], center_reg[1]});
    assign d_next[2] = $signed({point.point_z[COORD_W-1], point.point_z})
                     - $signed({center_reg[2][COORD_W-1], center_reg[2]});

    // Stage 2: rotation column k times offset component j.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[k][j] = $signed(dir_reg[k][j*DIR_W +: DIR_W]) * d_reg[j];
            end
        end
    end

    // Stage 3: dot product and magnitude.
    always_comb
    begin
        logic signed [LOCAL_W-1:0] loc;
        logic signed [LOCAL_W-1:0] neg;
        for (int k = 0; k < 3; k++)
        begin
            loc = LOCAL_W'(prod_reg[k][0]) + LOCAL_W'(prod_reg[k][1])
                + LOCAL_W'(prod_reg[k][2]);
            neg = -loc;
            mag_next[k] = loc[LOCAL_W-1] ? neg[MAG_W-1:0] : loc[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            d_reg <= d_next;
        end
        if (adv[2])
        begin
            prod_reg <= prod_next;
        end
        if (adv[3])
        begin
            mag_reg <= mag_next;
        end
    end

    // Stages 4 to 6: one lane per ellipsoid axis.
    assign lane_en.mul_en   = adv[4];
    assign lane_en.split_en = adv[5];
    assign lane_en.sq_en    = adv[6];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        pie_term_lane u_lane (
            .clk  (clk),
            .en   (lane_en),
            .mag  (mag_reg[k]),
            .inv  (inv_reg[k*INV_W +: INV_W]),
            .over (over6[k]),
            .sq   (sq6[k])
        );
    end

    // Stage 7: sum and compare; any term above 1.0 means outside.
    assign sum = SUM_W'(sq6[0]) + SUM_W'(sq6[1]) + SUM_W'(sq6[2]);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            inside_reg <= (over6 == 3'b000) && (sum <= SUM_ONE);
        end
    end

    assign result.valid      = v_reg[NUM_STAGES];
    assign result.inside_res = inside_reg;

    `PIE_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !point.ready, (&v_reg), "input stalled with a bubble in the pipe")
    `PIE_ASSERT_NEXT(a_accept_lands, clk, rst_n, point.valid && point.ready, v_reg[1], "accepted beat missing from stage one")
    `PIE_ASSERT_NEXT(a_over_outside, clk, rst_n, v_reg[6] && adv[7] && (over6 != 3'b000), !result.inside_res, "term above one reported inside")
    `PIE_ASSERT_NEXT(a_out_hold, clk, rst_n, v_reg[7] && !result.ready, v_reg[7] && $stable(inside_reg), "pending result lost")
endmodule

`default_nettype wire
